/* rtl/core/odp_pkg.sv */
// odp_pkg: shared constants, result word type and small lookup functions
// for the ordered-dither palette converter; no dependencies
package odp_pkg;

    localparam int COORD_BITS = 12;
    localparam int BPL_BITS   = 13;
    localparam int OFF_BITS   = 24;
    localparam int CLR_BITS   = 24;
    localparam int IDX_BITS   = 8;
    localparam int CH_BITS    = 8;

    localparam logic [BPL_BITS-1:0] BPL_RESET  = 13'd1024;
    localparam logic [OFF_BITS-1:0] OFFSET_MAX = 24'hFFFFFF;

    localparam logic CMD_PUT = 1'b0;
    localparam logic CMD_GET = 1'b1;

    localparam logic [IDX_BITS-1:0] GRAY_END = 8'd16;
    localparam logic [IDX_BITS-1:0] CUBE_BASE = 8'd40;

    typedef struct packed {
        logic [OFF_BITS-1:0] byte_offset;
        logic [IDX_BITS-1:0] index_out;
        logic [CH_BITS-1:0]  red_out;
        logic [CH_BITS-1:0]  green_out;
        logic [CH_BITS-1:0]  blue_out;
    } t_result;

    typedef struct packed {
        logic [CH_BITS-1:0] red;
        logic [CH_BITS-1:0] green;
        logic [CH_BITS-1:0] blue;
    } t_rgb;

    // 4x4 ordered-dither threshold offsets, (49*rank+7)/15+1, by row then column
    function automatic logic [5:0] dither_offset(input logic [1:0] row, input logic [1:0] col);
        logic [5:0] t;
        case ({row, col})
            4'h0: t = 6'd1;
            4'h1: t = 6'd37;
            4'h2: t = 6'd4;
            4'h3: t = 6'd34;
            4'h4: t = 6'd47;
            4'h5: t = 6'd14;
            4'h6: t = 6'd50;
            4'h7: t = 6'd17;
            4'h8: t = 6'd8;
            4'h9: t = 6'd30;
            4'hA: t = 6'd11;
            4'hB: t = 6'd27;
            4'hC: t = 6'd40;
            4'hD: t = 6'd21;
            4'hE: t = 6'd43;
            default: t = 6'd24;
        endcase
        return t;
    endfunction

    // cube level 0..5 to channel value, level*252/5
    function automatic logic [CH_BITS-1:0] cube_scale(input logic [2:0] lvl);
        logic [CH_BITS-1:0] v;
        case (lvl)
            3'd0: v = 8'd0;
            3'd1: v = 8'd50;
            3'd2: v = 8'd100;
            3'd3: v = 8'd151;
            3'd4: v = 8'd201;
            3'd5: v = 8'd252;
            default: v = 8'd0;
        endcase
        return v;
    endfunction

endpackage

/* rtl/core/odp_if.sv */
// odp_if: valid/ready channel interfaces for pixel commands, result words
// and stride configuration; depends on odp_pkg
interface odp_in_if #(
    parameter int COORD_BITS = odp_pkg::COORD_BITS
);
    logic                          valid;
    logic                          ready;
    logic                          command;
    logic [COORD_BITS-1:0]         pos_x;
    logic [COORD_BITS-1:0]         pos_y;
    logic [odp_pkg::CLR_BITS-1:0]  colour_in;
    logic [odp_pkg::IDX_BITS-1:0]  pixel_index;

    modport source (output valid, command, pos_x, pos_y, colour_in, pixel_index, input ready);
    modport sink   (input valid, command, pos_x, pos_y, colour_in, pixel_index, output ready);
endinterface

interface odp_out_if;
    logic                          valid;
    logic                          ready;
    logic [odp_pkg::OFF_BITS-1:0]  byte_offset;
    logic [odp_pkg::IDX_BITS-1:0]  index_out;
    logic [odp_pkg::CH_BITS-1:0]   red_out;
    logic [odp_pkg::CH_BITS-1:0]   green_out;
    logic [odp_pkg::CH_BITS-1:0]   blue_out;

    modport source (output valid, byte_offset, index_out, red_out, green_out, blue_out,
                    input ready);
    modport sink   (input valid, byte_offset, index_out, red_out, green_out, blue_out,
                    output ready);
endinterface

interface odp_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [odp_pkg::BPL_BITS-1:0]  bytes_per_line;

    modport source (output valid, bytes_per_line, input ready);
    modport sink   (input valid, bytes_per_line, output ready);
endinterface

/* rtl/core/ordered_dither_rgb_to_palette.sv */
// ordered_dither_rgb_to_palette: top level, input register, offset, dither
// and palette logic, result register; depends on odp_pkg, odp_if, odp_offset,
// odp_dither and odp_palette
//
// i_pix takes one command word per cycle while ready: put dithers colour_in
// at (pos_x, pos_y) into a palette index, get expands pixel_index to rgb.
// o_res gives one result word per command, in order: byte offset of the
// pixel, index and (for get) palette colour.
// i_cfg writes the row stride bytes_per_line; always ready. The user must
// write it only while no command is in flight; the block does not enforce it.
// a taken word passes through the input register and then the result
// register to o_res; throughput is one word per cycle while o_res.ready
// is high, and no item depends on an earlier one.
// when o_res.ready is low the result register holds its word and the input
// register keeps accepting until it too is full, then i_pix.ready drops.
// reset empties both registers and sets the stride to 1024.
module ordered_dither_rgb_to_palette #(
    parameter int COORD_BITS = odp_pkg::COORD_BITS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    odp_in_if.sink       i_pix,
    odp_cfg_if.sink      i_cfg,
    odp_out_if.source    o_res
);
    logic                          r_s1_valid;
    logic                          r_s1_cmd;
    logic [COORD_BITS-1:0]         r_s1_x;
    logic [COORD_BITS-1:0]         r_s1_y;
    logic [odp_pkg::CLR_BITS-1:0]  r_s1_clr;
    logic [odp_pkg::IDX_BITS-1:0]  r_s1_idx;
    logic                          r_s2_valid;
    odp_pkg::t_result              r_s2;
    odp_pkg::t_result              n_s2;
    logic [odp_pkg::BPL_BITS-1:0]  r_bpl;

    logic                          s1_ready;
    logic                          s2_ready;
    logic [odp_pkg::OFF_BITS-1:0]  offset;
    logic [odp_pkg::IDX_BITS-1:0]  put_index;
    odp_pkg::t_rgb                 get_rgb;

    assign s2_ready    = !r_s2_valid || o_res.ready;
    assign s1_ready    = !r_s1_valid || s2_ready;
    assign i_pix.ready = s1_ready;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpl <= odp_pkg::BPL_RESET;
        end else if (i_cfg.valid) begin
            r_bpl <= i_cfg.bytes_per_line;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready && i_pix.valid) begin
            r_s1_cmd <= i_pix.command;
            r_s1_x   <= i_pix.pos_x;
            r_s1_y   <= i_pix.pos_y;
            r_s1_clr <= i_pix.colour_in;
            r_s1_idx <= i_pix.pixel_index;
        end
    end

    odp_offset #(
        .COORD_BITS (COORD_BITS)
    ) u_offset (
        .i_x      (r_s1_x),
        .i_y      (r_s1_y),
        .i_bpl    (r_bpl),
        .o_offset (offset)
    );

    odp_dither u_dither (
        .i_colour (r_s1_clr),
        .i_col    (r_s1_x[1:0]),
        .i_row    (r_s1_y[1:0]),
        .o_index  (put_index)
    );

    odp_palette u_palette (
        .i_index (r_s1_idx),
        .o_rgb   (get_rgb)
    );

    always_comb begin
        n_s2.byte_offset = offset;
        if (r_s1_cmd == odp_pkg::CMD_GET) begin
            n_s2.index_out = r_s1_idx;
            n_s2.red_out   = get_rgb.red;
            n_s2.green_out = get_rgb.green;
            n_s2.blue_out  = get_rgb.blue;
        end else begin
            n_s2.index_out = put_index;
            n_s2.red_out   = '0;
            n_s2.green_out = '0;
            n_s2.blue_out  = '0;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_ready) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_ready && r_s1_valid) begin
            r_s2 <= n_s2;
        end
    end

    assign o_res.valid       = r_s2_valid;
    assign o_res.byte_offset = r_s2.byte_offset;
    assign o_res.index_out   = r_s2.index_out;
    assign o_res.red_out     = r_s2.red_out;
    assign o_res.green_out   = r_s2.green_out;
    assign o_res.blue_out    = r_s2.blue_out;
endmodule

/* rtl/core/odp_offset.sv */
// odp_offset: framebuffer byte offset x + y * stride, saturated to 24 bits
// depends on odp_pkg
module odp_offset #(
    parameter int COORD_BITS = odp_pkg::COORD_BITS
) (
    input  logic [COORD_BITS-1:0]        i_x,
    input  logic [COORD_BITS-1:0]        i_y,
    input  logic [odp_pkg::BPL_BITS-1:0] i_bpl,
    output logic [odp_pkg::OFF_BITS-1:0] o_offset
);
    localparam int PW = COORD_BITS + odp_pkg::BPL_BITS;
    localparam int SW = PW + 1;
    localparam int WW = (SW > odp_pkg::OFF_BITS) ? SW : odp_pkg::OFF_BITS;

    logic [PW-1:0] prod;
    logic [WW-1:0] sum;

    always_comb begin
        prod = PW'(i_y) * PW'(i_bpl);
        sum  = WW'(prod) + WW'(i_x);
        if (sum > WW'(odp_pkg::OFFSET_MAX)) begin
            o_offset = odp_pkg::OFFSET_MAX;
        end else begin
            o_offset = sum[odp_pkg::OFF_BITS-1:0];
        end
    end
endmodule

/* rtl/core/odp_dither.sv */
// odp_dither: put path, gray detection and 4x4 ordered dither into the
// 6x6x6 colour cube; depends on odp_pkg
module odp_dither (
    input  logic [odp_pkg::CLR_BITS-1:0] i_colour,
    input  logic [1:0]                   i_col,
    input  logic [1:0]                   i_row,
    output logic [odp_pkg::IDX_BITS-1:0] o_index
);
    logic [5:0]  t;
    logic [7:0]  r, g, b;
    logic [10:0] pr, pg, pb;
    logic [2:0]  lr, lg, lb;

    always_comb begin
        r  = i_colour[23:16];
        g  = i_colour[15:8];
        b  = i_colour[7:0];
        t  = odp_pkg::dither_offset(i_row, i_col);
        pr = (11'(r) + 11'(t)) * 11'd5;
        pg = (11'(g) + 11'(t)) * 11'd5;
        pb = (11'(b) + 11'(t)) * 11'd5;
        lr = pr[10:8];
        lg = pg[10:8];
        lb = pb[10:8];
        if (r[7:4] == g[7:4] && g[7:4] == b[7:4]) begin
            o_index = {4'd0, r[7:4]};
        end else begin
            o_index = 8'(lr) * 8'd36 + 8'(lg) * 8'd6 + 8'(lb) + odp_pkg::CUBE_BASE;
        end
    end
endmodule

/* rtl/core/odp_palette.sv */
// odp_palette: get path, expands a palette index to rgb (gray ramp, white
// band, colour cube); depends on odp_pkg
module odp_palette (
    input  logic [odp_pkg::IDX_BITS-1:0] i_index,
    output odp_pkg::t_rgb                o_rgb
);
    logic [7:0]  k;
    logic [15:0] p6;
    logic [5:0]  q6;
    logic [10:0] p36;
    logic [2:0]  q36;
    logic [7:0]  rb;
    logic [5:0]  rg;

    // k/6 as (k*171)>>10 and (k/6)/6 as (q*43)>>8, exact over 0..215
    always_comb begin
        k   = i_index - odp_pkg::CUBE_BASE;
        p6  = 16'(k) * 16'd171;
        q6  = p6[15:10];
        p36 = 11'(q6) * 11'd43;
        q36 = p36[10:8];
        rb  = k - 8'(q6) * 8'd6;
        rg  = q6 - 6'(q36) * 6'd6;
        if (i_index < odp_pkg::GRAY_END) begin
            o_rgb.red   = {i_index[3:0], 4'd0};
            o_rgb.green = {i_index[3:0], 4'd0};
            o_rgb.blue  = {i_index[3:0], 4'd0};
        end else if (i_index < odp_pkg::CUBE_BASE) begin
            o_rgb.red   = 8'hFF;
            o_rgb.green = 8'hFF;
            o_rgb.blue  = 8'hFF;
        end else begin
            o_rgb.red   = odp_pkg::cube_scale(q36);
            o_rgb.green = odp_pkg::cube_scale(rg[2:0]);
            o_rgb.blue  = odp_pkg::cube_scale(rb[2:0]);
        end
    end
endmodule

/* rtl/core/odp_checker.sv */
// odp_checker: port-level assertions for ordered_dither_rgb_to_palette,
// bound to the top level; depends on odp_pkg
module odp_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [odp_pkg::OFF_BITS-1:0]  i_out_offset,
    input  logic [odp_pkg::IDX_BITS-1:0]  i_out_index
);
    // an accepted word shows up via both registers (or something older still waits)
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |-> ##2 i_out_valid)
        else $error("result word missing two cycles after acceptance");

    // both registers full and stalled: no more words taken
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_in_valid && i_in_ready && i_out_valid && !i_out_ready)
         && i_out_valid && !i_out_ready) |-> !i_in_ready)
        else $error("word accepted with pipeline full");

    // reset leaves the output empty
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("result valid straight after reset");

    // stalled result word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
        (i_out_valid && $stable(i_out_offset) && $stable(i_out_index)))
        else $error("stalled result word changed");
endmodule

bind ordered_dither_rgb_to_palette odp_checker u_odp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_pix.valid),
    .i_in_ready   (i_pix.ready),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_out_offset (o_res.byte_offset),
    .i_out_index  (o_res.index_out)
);
